// ===== hw/rtl/lrs_pkg.sv =====
package lrs_pkg;

  // sample and rate widths
  localparam int SAMPLE_BITS = 16;
  localparam int RATE_BITS   = 18;
  localparam int SUM_BITS    = RATE_BITS + 1;
  localparam int PH_BITS     = 14;

  // rates in hertz
  localparam int unsigned TARGET_RATE = 16000;
  localparam int unsigned RATE_MIN    = 4000;
  localparam int unsigned RATE_MAX    = 192000;
  localparam int unsigned RATE_RESET  = 16000;

  // interpolation datapath widths
  localparam int DIFF_BITS    = SAMPLE_BITS + 1;
  localparam int PROD_BITS    = DIFF_BITS + PH_BITS;
  localparam int U_BITS       = SAMPLE_BITS + 15;
  localparam int TARGET_SHIFT = 7;
  localparam int TARGET_ODD   = TARGET_RATE >> TARGET_SHIFT;
  localparam int V_BITS       = U_BITS - TARGET_SHIFT;
  localparam int RECIP_SHIFT  = V_BITS + 7;
  localparam int RECIP_BITS   = RECIP_SHIFT - 6;
  localparam int MULT_BITS    = V_BITS + RECIP_BITS;
  localparam int Q_BITS       = MULT_BITS - RECIP_SHIFT;

  // reciprocal of the odd part of the target rate, rounded up
  localparam longint unsigned RECIP_WIDE =
    ((64'd1 << RECIP_SHIFT) + 64'(TARGET_ODD) - 64'd1) / 64'(TARGET_ODD);
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_WIDE);

  // offset making the product non-negative, plus half for rounding
  localparam longint unsigned BIAS_WIDE =
    ((64'd1 << SAMPLE_BITS) * 64'(TARGET_RATE)) + 64'(TARGET_RATE / 2);

  // queue depths
  localparam int CMD_DEPTH_DEFAULT    = 2;
  localparam int RESULT_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pcm_sample;
    logic                          final_sample;
  } lrs_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          run_last;
    logic                          signal_end;
  } lrs_out_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pcm_sample;
    logic                          final_sample;
    logic [RATE_BITS-1:0]          rate;
  } lrs_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_TAIL
  } lrs_state_t;

endpackage

// ===== hw/rtl/linear_resampler_to_16k_top.sv =====
// linear resampler to 16 khz
//
// input channel: push a beat on item (sample plus last-sample flag) while
// full is low. result channel: while empty is low the oldest result sits on
// result and leaves with pop. the user must write the input rate register
// through rate_we / rate_data only while the block is idle; the block itself
// does not enforce it. values outside 4000..192000 are clamped when an item
// is taken in. path: a beat accepted into an idle block passes the input
// queue, the sequencer, the multiply and the reciprocal multiply registers.
// flow: the sequencer takes an item from the input queue only when idle and
// then issues one result per cycle while the result queue has room; a step
// against the held sample that makes no output, and a last-sample tail
// entered without output, each take a sequencer step of their own.
// stalls: results wait in a RESULT_DEPTH-deep queue; the sequencer holds
// while every slot is spoken for, and CMD_DEPTH input beats queue up ahead
// of it, after which full goes high.
// reset: both queues empty, no previous sample, phase zero, rate 16000.
module linear_resampler_to_16k_top #(
  parameter int CMD_DEPTH    = lrs_pkg::CMD_DEPTH_DEFAULT,
  parameter int RESULT_DEPTH = lrs_pkg::RESULT_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rate_we,
  input  logic [lrs_pkg::RATE_BITS-1:0] rate_data,
  input  logic                          push,
  input  lrs_pkg::lrs_in_t              item,
  output logic                          full,
  input  logic                          pop,
  output lrs_pkg::lrs_out_t             result,
  output logic                          empty
);
  import lrs_pkg::*;

  lrs_cmd_t cmd;
  logic     cmd_empty;
  logic     cmd_pop;
  logic     res_push;
  lrs_out_t res_data;
  logic     res_taken;
  logic     res_full;

  // a result beat leaves the block
  assign res_taken = pop && !empty;

  // front: rate register, clamp, input queue
  lrs_front #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rate_we  (rate_we),
    .rate_data(rate_data),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  // back: phase sequencer and interpolation pipeline
  lrs_back #(
    .RESULT_DEPTH(RESULT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res_data (res_data),
    .res_taken(res_taken)
  );

  // result queue; the back end reserves a slot before issuing, so it never
  // overflows
  lrs_queue #(
    .WIDTH($bits(lrs_out_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_result_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_data),
    .full (res_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result beat pushed into a full result queue");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown(result))
    else $error("unknown result beat on offer");

  a_flags_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({full, empty}))
    else $error("unknown queue flag");

endmodule

// ===== hw/rtl/lrs_queue.sv =====
module lrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/lrs_front.sv =====
module lrs_front #(
  parameter int CMD_DEPTH = lrs_pkg::CMD_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rate_we,
  input  logic [lrs_pkg::RATE_BITS-1:0]  rate_data,
  input  logic                           push,
  input  lrs_pkg::lrs_in_t               item,
  output logic                           full,
  input  logic                           cmd_pop,
  output lrs_pkg::lrs_cmd_t              cmd,
  output logic                           cmd_empty
);
  import lrs_pkg::*;

  logic [RATE_BITS-1:0] rate;
  logic [RATE_BITS-1:0] rate_eff;
  lrs_cmd_t             cmd_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_BITS'(RATE_RESET);
    end else if (rate_we) begin
      rate <= rate_data;
    end
  end

  // clamp to the supported range
  always_comb begin
    if (rate < RATE_BITS'(RATE_MIN)) begin
      rate_eff = RATE_BITS'(RATE_MIN);
    end else if (rate > RATE_BITS'(RATE_MAX)) begin
      rate_eff = RATE_BITS'(RATE_MAX);
    end else begin
      rate_eff = rate;
    end
  end

  always_comb begin
    cmd_in.pcm_sample   = item.pcm_sample;
    cmd_in.final_sample = item.final_sample;
    cmd_in.rate         = rate_eff;
  end

  lrs_queue #(
    .WIDTH($bits(lrs_cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cmd),
    .empty(cmd_empty)
  );

endmodule

// ===== hw/rtl/lrs_back.sv =====
module lrs_back #(
  parameter int RESULT_DEPTH = lrs_pkg::RESULT_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  lrs_pkg::lrs_cmd_t  cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               res_push,
  output lrs_pkg::lrs_out_t  res_data,
  input  logic               res_taken
);
  import lrs_pkg::*;

  localparam int CNT_BITS     = $clog2(RESULT_DEPTH + 1);
  localparam int SB           = SAMPLE_BITS;
  localparam int OUT_SUM_BITS = SB + 3;
  localparam logic signed [OUT_SUM_BITS-1:0] Q_OFFSET = {3'b001, {SB{1'b0}}};

  lrs_state_t state, state_next;

  // signal state
  logic signed [SB-1:0]  prev, prev_next;
  logic                  have_prev, have_next;
  logic [RATE_BITS-1:0]  acc, acc_next;

  // item being stepped
  logic signed [SB-1:0]        cur, cur_next;
  logic                        fin, fin_next;
  logic [RATE_BITS-1:0]        rate, rate_next;
  logic [RATE_BITS-1:0]        ph, ph_next;
  logic signed [SB-1:0]        base, base_next;
  logic signed [DIFF_BITS-1:0] diff, diff_next;

  logic [CNT_BITS-1:0] outstanding;
  logic                room;
  logic                issue;
  logic                finish_signal;

  logic [SUM_BITS-1:0] ph1;
  logic [SUM_BITS-1:0] ph2;
  logic                ph_low;
  logic                interp_emit;
  logic                tail_emit;
  logic                more;
  logic                to_tail;

  logic signed [PROD_BITS-1:0] prod_issue;
  logic signed [U_BITS:0]      u_wide;
  logic [V_BITS-1:0]           v;
  logic [MULT_BITS-1:0]        mult;

  // pipeline
  logic                        s1_valid;
  logic signed [PROD_BITS-1:0] s1_prod;
  logic signed [SB-1:0]        s1_base;
  logic                        s1_run_last;
  logic                        s1_signal_end;
  logic                        s2_valid;
  logic [MULT_BITS-1:0]        s2_mult;
  logic signed [SB-1:0]        s2_base;
  logic                        s2_run_last;
  logic                        s2_signal_end;
  logic [Q_BITS-1:0]           q;
  logic signed [OUT_SUM_BITS-1:0] out_sum;

  assign room = (outstanding < CNT_BITS'(RESULT_DEPTH));

  // phase look-ahead
  assign ph1         = SUM_BITS'(ph) + SUM_BITS'(rate);
  assign ph2         = ph1 + SUM_BITS'(rate);
  assign ph_low      = (ph < RATE_BITS'(TARGET_RATE));
  assign interp_emit = ph_low && !(fin && (ph1 > SUM_BITS'(2 * TARGET_RATE)));
  assign tail_emit   = (ph1 <= SUM_BITS'(TARGET_RATE));
  assign to_tail     = fin && (ph1 >= SUM_BITS'(TARGET_RATE));

  always_comb begin
    if (state == ST_TAIL) begin
      more = (ph2 <= SUM_BITS'(TARGET_RATE));
    end else if (fin) begin
      more = (ph2 <= SUM_BITS'(2 * TARGET_RATE));
    end else begin
      more = (ph1 < SUM_BITS'(TARGET_RATE));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (have_prev) begin
            state_next = ST_INTERP;
          end else if (cmd.final_sample) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_INTERP: begin
        if (room) begin
          if (interp_emit) begin
            if (!more) begin
              state_next = ST_IDLE;
            end else if (to_tail) begin
              state_next = ST_TAIL;
            end
          end else if (!ph_low && fin) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (room && !(tail_emit && more)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and register updates
  always_comb begin
    cmd_pop       = 1'b0;
    issue         = 1'b0;
    finish_signal = 1'b0;
    prev_next     = prev;
    have_next     = have_prev;
    acc_next      = acc;
    cur_next      = cur;
    fin_next      = fin;
    rate_next     = rate;
    ph_next       = ph;
    base_next     = base;
    diff_next     = diff;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cur_next  = cmd.pcm_sample;
          fin_next  = cmd.final_sample;
          rate_next = cmd.rate;
          ph_next   = acc;
          if (have_prev) begin
            base_next = prev;
            diff_next = DIFF_BITS'(cmd.pcm_sample) - DIFF_BITS'(prev);
          end else begin
            base_next = cmd.pcm_sample;
            diff_next = '0;
            if (!cmd.final_sample) begin
              prev_next = cmd.pcm_sample;
              have_next = 1'b1;
            end
          end
        end
      end
      ST_INTERP: begin
        if (room) begin
          if (interp_emit) begin
            issue = 1'b1;
            if (more) begin
              if (to_tail) begin
                ph_next   = RATE_BITS'(ph1 - SUM_BITS'(TARGET_RATE));
                base_next = cur;
                diff_next = '0;
              end else begin
                ph_next = ph1[RATE_BITS-1:0];
              end
            end else if (fin) begin
              finish_signal = 1'b1;
            end else begin
              prev_next = cur;
              have_next = 1'b1;
              acc_next  = RATE_BITS'(ph1 - SUM_BITS'(TARGET_RATE));
            end
          end else if (!ph_low) begin
            if (fin) begin
              ph_next   = ph - RATE_BITS'(TARGET_RATE);
              base_next = cur;
              diff_next = '0;
            end else begin
              prev_next = cur;
              have_next = 1'b1;
              acc_next  = ph - RATE_BITS'(TARGET_RATE);
            end
          end else begin
            // last sample stops the interpolation before any output
            finish_signal = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (room) begin
          if (tail_emit) begin
            issue = 1'b1;
            if (more) begin
              ph_next = ph1[RATE_BITS-1:0];
            end else begin
              finish_signal = 1'b1;
            end
          end else begin
            finish_signal = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (finish_signal) begin
      prev_next = '0;
      have_next = 1'b0;
      acc_next  = '0;
    end
  end

  // interpolation datapath: d*ph, then divide by the target rate
  assign prod_issue = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, ph[PH_BITS-1:0]}));
  assign u_wide     = (U_BITS + 1)'(s1_prod) + $signed((U_BITS + 1)'(BIAS_WIDE));
  assign v          = u_wide[U_BITS-1:TARGET_SHIFT];
  assign mult       = {{RECIP_BITS{1'b0}}, v} * {{V_BITS{1'b0}}, RECIP};
  assign q          = s2_mult[MULT_BITS-1:RECIP_SHIFT];
  assign out_sum    = OUT_SUM_BITS'(s2_base) + $signed({1'b0, q}) - Q_OFFSET;

  assign res_push            = s2_valid;
  assign res_data.out_sample = out_sum[SB-1:0];
  assign res_data.run_last   = s2_run_last;
  assign res_data.signal_end = s2_signal_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev        <= '0;
      have_prev   <= 1'b0;
      acc         <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      outstanding <= '0;
    end else begin
      state     <= state_next;
      prev      <= prev_next;
      have_prev <= have_next;
      acc       <= acc_next;
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      if (issue && !res_taken) begin
        outstanding <= outstanding + 1'b1;
      end else if (res_taken && !issue) begin
        outstanding <= outstanding - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur           <= cur_next;
    fin           <= fin_next;
    rate          <= rate_next;
    ph            <= ph_next;
    base          <= base_next;
    diff          <= diff_next;
    s1_prod       <= prod_issue;
    s1_base       <= base;
    s1_run_last   <= !more;
    s1_signal_end <= !more && fin;
    s2_mult       <= mult;
    s2_base       <= s1_base;
    s2_run_last   <= s1_run_last;
    s2_signal_end <= s1_signal_end;
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_BITS'(RESULT_DEPTH))
    else $error("result credit count above queue depth");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_push && res_data.signal_end |-> res_data.run_last)
    else $error("signal end on a result that is not the last of its item");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    !have_prev |-> acc == '0)
    else $error("phase left over with no previous sample held");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    have_prev |-> acc < RATE_BITS'(RATE_MAX))
    else $error("phase accumulator out of range");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != ST_IDLE) || have_prev)
    else $error("item taken but neither stepped nor held");

endmodule

// ===== tb/sv/linear_resampler_to_16k_top_tb.sv =====
`timescale 1ns / 100ps

module linear_resampler_to_16k_top_tb;
  import lrs_pkg::*;

  // signed copies of the rate constants, so interpolation arithmetic stays signed
  localparam longint TARGET_L = TARGET_RATE;
  localparam longint MIN_L    = RATE_MIN;
  localparam longint MAX_L    = RATE_MAX;
  localparam longint HALF_L   = longint'(1) << (SAMPLE_BITS - 1);
  localparam longint BIAS_L   = HALF_L * TARGET_L + TARGET_L / 2;
  localparam longint PH_MASK  = (longint'(1) << RATE_BITS) - 1;

  // cycles allowed after the last result for beats that make no output
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 rate_we = 1'b0;
  logic [RATE_BITS-1:0] rate_data = '0;
  logic                 push = 1'b0;
  lrs_in_t              item = '0;
  logic                 full;
  logic                 pop = 1'b0;
  lrs_out_t             result;
  logic                 empty;

  linear_resampler_to_16k_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .rate_we   (rate_we),
    .rate_data (rate_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

  always #2 clk = ~clk;

  // beats waiting to be offered, and samples the resampler should produce
  lrs_in_t  pending[$];
  lrs_out_t expected_samples[$];

  // shadow of the resampler: held sample, phase and the rate register
  logic [RATE_BITS-1:0] rate_reg = RATE_BITS'(RATE_RESET);
  longint               held_sample = 0;
  bit                   held_valid = 1'b0;
  longint               phase_acc = 0;

  int       mismatch_count = 0;
  bit       calm = 1'b0;        // no idling on either side while set
  bit       hold_req = 1'b0;    // asks the receiver for one long hold-off
  bit       hold_done = 1'b0;
  int       hold_left = 0;
  lrs_out_t want;

  // rounded (a*(16000-ph) + b*ph) / 16000, halves go up
  function automatic logic [SAMPLE_BITS-1:0] interpolate(longint a, longint b, longint ph);
    longint num;
    num = a * (TARGET_L - ph) + b * ph;
    return SAMPLE_BITS'((num + BIAS_L) / TARGET_L - HALF_L);
  endfunction

  // predict every output sample caused by one input beat
  task automatic resample_step(input lrs_in_t beat);
    longint   cur;
    longint   rate;
    longint   ph;
    bit       fin;
    bit       stopped;
    lrs_out_t batch[$];
    lrs_out_t r;
    cur     = longint'($signed(beat.pcm_sample));
    fin     = beat.final_sample;
    rate    = longint'(rate_reg);
    ph      = phase_acc;
    stopped = 1'b0;
    if (rate < MIN_L) rate = MIN_L;
    if (rate > MAX_L) rate = MAX_L;

    // outputs between the held sample and this one
    if (held_valid) begin
      while (ph < TARGET_L) begin
        // on the last sample, positions beyond it are covered by the tail
        if (fin && ph + rate > 2 * TARGET_L) begin
          stopped = 1'b1;
          break;
        end
        r            = '0;
        r.out_sample = interpolate(held_sample, cur, ph);
        batch.insert(batch.size(), r);
        ph += rate;
      end
      if (!stopped) ph -= TARGET_L;
    end

    if (fin) begin
      // tail: clamped index repeats the last sample
      if (!stopped) begin
        while (ph < TARGET_L && ph + rate <= TARGET_L) begin
          r            = '0;
          r.out_sample = beat.pcm_sample;
          batch.insert(batch.size(), r);
          ph += rate;
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].signal_end = 1'b1;
      held_sample = 0;
      held_valid  = 1'b0;
      phase_acc   = 0;
    end else begin
      held_sample = cur;
      held_valid  = 1'b1;
      phase_acc   = ph & PH_MASK;
    end

    if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
    foreach (batch[k]) expected_samples.insert(expected_samples.size(), batch[k]);
  endtask

  // input beat taken: predict, then retire it from the pending list
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      resample_step(item);
      void'(pending.pop_front());
    end
  end

  // driver: offers the oldest pending beat, idling now and then
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
      push <= 1'b1;
      item <= pending[0];
    end else begin
      push <= 1'b0;
    end
  end

  // receiver: random pop, plus one long hold-off so the input side backs up
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // monitor: every result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: sample %0d run_last %0b signal_end %0b",
                   $signed(result.out_sample), result.run_last, result.signal_end);
      end else begin
        want = expected_samples.pop_front();
        if (result !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected sample %0d run_last %0b signal_end %0b, got %0d %0b %0b",
                     $signed(want.out_sample), want.run_last, want.signal_end,
                     $signed(result.out_sample), result.run_last, result.signal_end);
        end
      end
    end
  end

  task automatic add_beat(input int sample, input bit fin);
    lrs_in_t b;
    b.pcm_sample   = SAMPLE_BITS'(sample);
    b.final_sample = fin;
    pending.insert(pending.size(), b);
  endtask

  // register write, only ever called with the block idle
  task automatic write_rate(input int unsigned value);
    @(negedge clk);
    rate_we   <= 1'b1;
    rate_data <= RATE_BITS'(value);
    rate_reg   = RATE_BITS'(value);
    @(negedge clk);
    rate_we   <= 1'b0;
  endtask

  // all beats taken, all results out, then a margin for silent beats
  task automatic drain_and_wait();
    wait (pending.size() == 0);
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int unsigned pick_rate();
    int unsigned common_rates[6] = '{8000, 11025, 22050, 32000, 44100, 48000};
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, (1 << RATE_BITS) - 1);   // may be clamped
      1:       return common_rates[$urandom_range(0, 5)];
      2, 3, 4: return $urandom_range(RATE_MIN, 32000);           // upsampling heavy
      default: return $urandom_range(RATE_MIN, RATE_MAX);
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32767;
      1:       return -32768;
      2:       return $urandom_range(0, 15) - 8;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // signals of random length; now and then one is left open across the phase end
  task automatic fill_signals(input int count);
    int len;
    int n;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
      for (int k = 0; k < len && n < count; k++) begin
        add_beat(pick_sample(), (k == len - 1) && ($urandom_range(0, 5) != 0));
        n++;
      end
    end
  endtask

  initial begin
    int total;
    int count;
    int phase_no;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset rate keeps the sample rate, extremes of the sample
    add_beat(32767, 1'b0);
    add_beat(-32768, 1'b0);
    add_beat(0, 1'b0);
    add_beat(-1, 1'b0);
    add_beat(12345, 1'b1);
    add_beat(-32768, 1'b1);          // single-sample signal
    drain_and_wait();

    // lowest rate: four outputs per beat after the first, eight on the final beat
    write_rate(RATE_MIN);
    add_beat(32767, 1'b0);
    add_beat(-32768, 1'b0);
    add_beat(32767, 1'b1);
    add_beat(1000, 1'b1);            // single sample repeated
    drain_and_wait();

    // highest rate: downsampling, silent beats and an empty final beat
    write_rate(RATE_MAX);
    add_beat(100, 1'b0);
    add_beat(-100, 1'b0);
    add_beat(20000, 1'b0);
    add_beat(-20000, 1'b0);
    add_beat(5, 1'b1);
    drain_and_wait();

    // out of range below and above, clamped
    write_rate(0);
    add_beat(-1, 1'b0);
    add_beat(1, 1'b1);
    drain_and_wait();
    write_rate((1 << RATE_BITS) - 1);
    add_beat(7, 1'b1);
    drain_and_wait();

    // half-way points round upwards
    write_rate(8000);
    add_beat(0, 1'b0);
    add_beat(1, 1'b0);
    add_beat(0, 1'b0);
    add_beat(-1, 1'b1);
    drain_and_wait();

    write_rate(44100);
    add_beat(1000, 1'b0);
    add_beat(2000, 1'b0);
    add_beat(3000, 1'b1);
    drain_and_wait();

    // random phases, each under its own rate
    total    = 0;
    phase_no = 0;
    while (total < 290) begin
      count = $urandom_range(20, 45);
      write_rate(pick_rate());
      case (phase_no)
        1: begin
          // receiver holds off while the whole phase is on offer
          write_rate($urandom_range(RATE_MIN, 8000));
          fill_signals(count);
          hold_req = 1'b1;
        end
        2: begin
          calm = 1'b1;
          fill_signals(count);
        end
        3: begin
          // sender stops half way until every result is out
          fill_signals(count / 2);
          wait (pending.size() == 0);
          @(posedge clk);
          while (expected_samples.size() != 0) @(posedge clk);
          fill_signals(count - count / 2);
        end
        default: fill_signals(count);
      endcase
      drain_and_wait();
      calm  = 1'b0;
      total += count;
      phase_no++;
    end

    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("PASS linear_resampler_to_16k_top");
    end else begin
      $display("FAIL linear_resampler_to_16k_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL linear_resampler_to_16k_top");
    $finish;
  end

endmodule
